FILE: sv/stok_pkg.sv
`default_nettype none

package stok_pkg;

  // Position counter width; positions, starts and lengths saturate at all ones.
  localparam int unsigned PosBits = 16;
  // Width of the start and length fields of a result.
  localparam int unsigned FieldW  = 16;

  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChQuote  = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChNl     = 8'h0A;

  localparam logic KindByte = 1'b0;
  localparam logic KindEnd  = 1'b1;

  localparam logic [2:0] TokChar   = 3'd0;
  localparam logic [2:0] TokString = 3'd1;
  localparam logic [2:0] TokInt    = 3'd2;
  localparam logic [2:0] TokIdent  = 3'd3;
  localparam logic [2:0] TokError  = 3'd4;

  typedef enum logic [6:0] {
    ModeIdle      = 7'b0000001,
    ModeComment   = 7'b0000010,
    ModeCharBody  = 7'b0000100,
    ModeCharClose = 7'b0001000,
    ModeString    = 7'b0010000,
    ModeRun       = 7'b0100000,
    ModeHalt      = 7'b1000000
  } scan_mode_e;

  typedef logic [PosBits-1:0] pos_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_in;
  } stok_in_t;

  typedef struct packed {
    logic [2:0]        token_kind;
    logic [FieldW-1:0] token_start;
    logic [FieldW-1:0] token_length;
    logic              final_res;
  } stok_out_t;

  function automatic logic is_ws(logic [7:0] b);
    return ((b >= 8'd9) && (b <= 8'd13)) || (b == 8'd32);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'd48) && (b <= 8'd57);
  endfunction

  function automatic pos_t sat_inc(pos_t v);
    return (v == '1) ? v : v + pos_t'(1);
  endfunction

endpackage

`default_nettype wire

FILE: sv/stok_scan.sv
`default_nettype none

module stok_scan import stok_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire stok_in_t  item_i,
  output logic           res_valid_o,
  output stok_out_t      res_o
);

  scan_mode_e mode_q, mode_d;
  pos_t       pos_q, pos_d;
  pos_t       start_q, start_d;
  pos_t       len_q, len_d;
  logic       digits_q, digits_d;

  logic [7:0] b;
  logic       run_end;
  scan_mode_e open_mode;
  pos_t       open_start;
  pos_t       open_len;
  logic       open_digits;
  logic [2:0] run_kind;

  assign b        = item_i.byte_in;
  assign run_end  = is_ws(b) || (b == ChQuote) || (b == ChDquote) || (b == ChHash);
  assign run_kind = digits_q ? TokInt : TokIdent;

  // What a byte does when it may open a new token.
  always_comb begin
    open_start  = start_q;
    open_len    = len_q;
    open_digits = digits_q;
    priority if (is_ws(b)) begin
      open_mode = ModeIdle;
    end else if (b == ChHash) begin
      open_mode = ModeComment;
    end else if ((b == ChQuote) || (b == ChDquote)) begin
      open_mode  = (b == ChQuote) ? ModeCharBody : ModeString;
      open_start = sat_inc(pos_q);
      open_len   = '0;
    end else begin
      open_mode   = ModeRun;
      open_start  = pos_q;
      open_len    = pos_t'(1);
      open_digits = is_digit(b);
    end
  end

  always_comb begin
    mode_d      = mode_q;
    pos_d       = pos_q;
    start_d     = start_q;
    len_d       = len_q;
    digits_d    = digits_q;
    res_valid_o = 1'b0;
    res_o.token_kind   = TokError;
    res_o.token_start  = FieldW'(start_q);
    res_o.token_length = FieldW'(len_q);
    res_o.final_res    = 1'b0;

    if (item_i.kind == KindEnd) begin
      res_o.final_res = 1'b1;
      unique case (mode_q)
        ModeRun: begin
          res_valid_o      = 1'b1;
          res_o.token_kind = run_kind;
        end
        ModeCharBody, ModeCharClose, ModeString: begin
          res_valid_o = 1'b1;
        end
        default: ;
      endcase
      // back to reset values
      mode_d   = ModeIdle;
      pos_d    = '0;
      start_d  = '0;
      len_d    = '0;
      digits_d = 1'b1;
    end else begin
      unique case (mode_q)
        ModeIdle: begin
          mode_d   = open_mode;
          start_d  = open_start;
          len_d    = open_len;
          digits_d = open_digits;
        end
        ModeComment: begin
          if (b == ChNl) mode_d = ModeIdle;
        end
        ModeCharBody: begin
          len_d  = pos_t'(1);
          mode_d = ModeCharClose;
        end
        ModeCharClose: begin
          res_valid_o = 1'b1;
          if (b == ChQuote) begin
            res_o.token_kind   = TokChar;
            res_o.token_length = FieldW'(1);
            mode_d             = ModeIdle;
          end else begin
            mode_d = ModeHalt;
          end
        end
        ModeString: begin
          if (b == ChDquote) begin
            res_valid_o      = 1'b1;
            res_o.token_kind = TokString;
            mode_d           = ModeIdle;
          end else begin
            len_d = sat_inc(len_q);
          end
        end
        ModeRun: begin
          if (run_end) begin
            res_valid_o      = 1'b1;
            res_o.token_kind = run_kind;
            mode_d           = open_mode;
            start_d          = open_start;
            len_d            = open_len;
            digits_d         = open_digits;
          end else begin
            len_d = sat_inc(len_q);
            if (!is_digit(b)) digits_d = 1'b0;
          end
        end
        default: begin
          mode_d = ModeHalt;
        end
      endcase
      pos_d = sat_inc(pos_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeIdle;
      pos_q    <= '0;
      start_q  <= '0;
      len_q    <= '0;
      digits_q <= 1'b1;
    end else if (step_i) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      start_q  <= start_d;
      len_q    <= len_d;
      digits_q <= digits_d;
    end
  end

`ifndef ASSERT_OFF
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (item_i.kind == KindEnd) |=> (mode_q == ModeIdle) && (pos_q == '0))
    else $error("state not cleared after end marker");

  a_final_only_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.final_res |-> (item_i.kind == KindEnd))
    else $error("final result without end marker");

  a_char_len_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.token_kind == TokChar) |-> (res_o.token_length == FieldW'(1)))
    else $error("character token length not one");

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeHalt) && (item_i.kind == KindByte) |-> !res_valid_o)
    else $error("result while halted");
`endif

endmodule

`default_nettype wire

FILE: sv/source_tokenizer_core.sv
// Pipeline: an item passes the input register, then its result the result register.
// Throughput: one item per cycle unless out_ready_i holds the result register;
//   the scan state updates once per byte in one pass.
// Reset (rst_ni, async, active low): scanner idle, position zero, both stages empty.
`default_nettype none

module source_tokenizer_core import stok_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire stok_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output stok_out_t      out_data_o
);

  logic      in_valid_q, in_valid_d;
  stok_in_t  in_q;
  logic      out_valid_q, out_valid_d;
  stok_out_t out_q;
  logic      advance;
  logic      res_valid;
  stok_out_t res;

  // Process the held item once the result register can take its outcome.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  stok_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .item_i     (in_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_ready_o) in_valid_d = in_valid_i;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    if (advance && res_valid) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
